@@ sv/hmf_pkg.sv @@
// Shared types, codes and constants of the head unit message framer.
`default_nettype none

package hmf_pkg;

    typedef logic [2:0] cmd_t;

    localparam cmd_t CMD_BUTTON   = 3'd0;
    localparam cmd_t CMD_SPEED    = 3'd1;
    localparam cmd_t CMD_CAR_TRIP = 3'd2;
    localparam cmd_t CMD_TRIP_ONE = 3'd3;
    localparam cmd_t CMD_TRIP_TWO = 3'd4;
    localparam cmd_t CMD_TEMP     = 3'd5;

    localparam logic [7:0] FRAME_HEADER  = 8'hFD;
    localparam logic [7:0] KIND_BUTTON   = 8'h02;
    localparam logic [7:0] KIND_SPEED    = 8'h7D;
    localparam logic [7:0] SPEED_SUB     = 8'h03;
    localparam logic [7:0] KIND_CAR_TRIP = 8'h33;
    localparam logic [7:0] KIND_TRIP_ONE = 8'h34;
    localparam logic [7:0] KIND_TRIP_TWO = 8'h35;
    localparam logic [7:0] KIND_TEMP     = 8'h36;
    localparam logic [7:0] TEMP_SIGN     = 8'h80;
    localparam logic [7:0] CONS_MARKER   = 8'hFF;
    localparam logic [7:0] LEN_EXTRA     = 8'd2;

    localparam logic [15:0] SPEED_SCALE = 16'd100;
    localparam logic [15:0] CONS_LIMIT  = 16'd390;
    localparam logic [17:0] CONS_NUMER  = 18'd200000;

    localparam int PAYLOAD_DEPTH = 10;

    typedef logic [3:0] pos_t;

    typedef logic [1:0] sel_t;

    localparam sel_t SEL_HDR = 2'd0;
    localparam sel_t SEL_LEN = 2'd1;
    localparam sel_t SEL_PAY = 2'd2;
    localparam sel_t SEL_SUM = 2'd3;

    typedef struct packed {
        logic load;
        logic fill;
        logic push;
        sel_t sel;
    } dp_cmd_t;

    typedef struct packed {
        logic cmd_ok;
        logic div_busy;
        logic out_free;
        logic pay_last;
    } dp_status_t;

endpackage

`default_nettype wire

@@ sv/hmf_if.sv @@
// Handshake channels for message requests and framed output words.
`default_nettype none

interface hmf_req_if;
    logic              valid;
    logic              ready;
    logic [2:0]        command;
    logic [7:0]        small_value;
    logic [15:0]       word_a;
    logic [15:0]       word_b;
    logic [15:0]       consumption_hundredths;
    logic signed [7:0] temperature;

    modport source (
        output valid, command, small_value, word_a, word_b,
               consumption_hundredths, temperature,
        input  ready
    );
    modport sink (
        input  valid, command, small_value, word_a, word_b,
               consumption_hundredths, temperature,
        output ready
    );
endinterface

interface hmf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;

    modport source (output valid, out_byte, last_byte, input ready);
    modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

`default_nettype wire

@@ sv/hmf_recip_div.sv @@
// Bit-serial restoring divider for the rounded consumption reciprocal.
`default_nettype none

module hmf_recip_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [15:0] hundredths,
    output logic             busy,
    output logic [7:0]       quotient
);

    localparam logic [3:0] DIV_STEPS = 4'd9;

    logic [3:0]  cnt_reg;
    logic [3:0]  cnt_next;
    logic [18:0] rem_reg;
    logic [24:0] div_reg;
    logic [8:0]  quo_reg;
    logic [24:0] rem_ext;
    logic        fits;
    logic [24:0] diff;

    function automatic logic [18:0] CONS_NUMER_EXT(input logic [15:0] h);
        return {1'b0, hmf_pkg::CONS_NUMER} + {3'd0, h};
    endfunction

    assign busy    = (cnt_reg != 4'd0);
    assign rem_ext = {6'd0, rem_reg};
    assign fits    = (rem_ext >= div_reg);
    assign diff    = rem_ext - div_reg;

    // A quotient of 256 or more saturates.
    assign quotient = quo_reg[8] ? 8'hFF : quo_reg[7:0];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (start)
        begin
            cnt_next = DIV_STEPS;
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 4'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= CONS_NUMER_EXT(hundredths);
            div_reg <= {hundredths, 1'b0, 8'd0};
            quo_reg <= 9'd0;
        end
        else if (busy)
        begin
            if (fits)
            begin
                rem_reg <= diff[18:0];
            end
            quo_reg <= {quo_reg[7:0], fits};
            div_reg <= div_reg >> 1;
        end
    end

endmodule

`default_nettype wire

@@ sv/hmf_datapath.sv @@
// Datapath: request latch, payload store, checksum and output word register.
`default_nettype none

module hmf_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [2:0]          command,
    input  wire logic [7:0]          small_value,
    input  wire logic [15:0]         word_a,
    input  wire logic [15:0]         word_b,
    input  wire logic [15:0]         consumption_hundredths,
    input  wire logic signed [7:0]   temperature,
    input  wire hmf_pkg::dp_cmd_t    cmd,
    output hmf_pkg::dp_status_t      status,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [7:0]               out_byte,
    output logic                     last_byte
);

    hmf_pkg::cmd_t  cmd_reg;
    logic [7:0]     sv_reg;
    logic [15:0]    a_reg;
    logic [15:0]    b_reg;
    logic [15:0]    h_reg;
    logic [7:0]     t_reg;

    logic [7:0]     store_reg [hmf_pkg::PAYLOAD_DEPTH];
    logic [7:0]     fill_bytes [hmf_pkg::PAYLOAD_DEPTH];
    hmf_pkg::pos_t  fill_len;

    hmf_pkg::pos_t  len_reg;
    hmf_pkg::pos_t  len_next;
    hmf_pkg::pos_t  idx_reg;
    hmf_pkg::pos_t  idx_next;
    logic [7:0]     sum_reg;
    logic [7:0]     sum_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic [7:0]     out_byte_reg;
    logic           out_last_reg;
    logic [7:0]     byte_sel;
    logic [7:0]     pay_byte;

    logic           div_busy;
    logic [7:0]     div_quot;
    logic [15:0]    speed_scaled;
    logic [7:0]     temp_neg;
    logic [7:0]     temp_byte;
    logic [7:0]     cons_c1;
    logic [7:0]     cons_c2;

    hmf_recip_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (cmd.load),
        .hundredths (consumption_hundredths),
        .busy       (div_busy),
        .quotient   (div_quot)
    );

    assign speed_scaled = {8'd0, sv_reg} * hmf_pkg::SPEED_SCALE;
    assign temp_neg     = ~t_reg + 8'd1;
    assign temp_byte    = t_reg[7] ? (hmf_pkg::TEMP_SIGN + temp_neg) : t_reg;
    assign cons_c1      = (h_reg < hmf_pkg::CONS_LIMIT) ? hmf_pkg::CONS_MARKER : 8'h00;
    assign cons_c2      = (h_reg < hmf_pkg::CONS_LIMIT) ? 8'h00 : div_quot;
    assign pay_byte     = store_reg[idx_reg];

    assign status.cmd_ok   = (command <= hmf_pkg::CMD_TEMP);
    assign status.div_busy = div_busy;
    assign status.out_free = !out_valid_reg || out_ready;
    assign status.pay_last = (idx_reg == (len_reg - 4'd1));

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last_byte = out_last_reg;

    always_comb
    begin
        for (int i = 0; i < hmf_pkg::PAYLOAD_DEPTH; i++)
        begin
            fill_bytes[i] = 8'h00;
        end
        fill_len = 4'd2;
        unique case (cmd_reg)
            hmf_pkg::CMD_BUTTON:
            begin
                fill_bytes[0] = hmf_pkg::KIND_BUTTON;
                fill_bytes[1] = sv_reg;
                fill_len      = 4'd2;
            end
            hmf_pkg::CMD_SPEED:
            begin
                fill_bytes[0] = hmf_pkg::KIND_SPEED;
                fill_bytes[1] = hmf_pkg::SPEED_SUB;
                fill_bytes[2] = speed_scaled[15:8];
                fill_bytes[3] = speed_scaled[7:0];
                fill_len      = 4'd6;
            end
            hmf_pkg::CMD_CAR_TRIP:
            begin
                fill_bytes[0] = hmf_pkg::KIND_CAR_TRIP;
                fill_bytes[1] = cons_c1;
                fill_bytes[2] = cons_c2;
                fill_bytes[3] = a_reg[15:8];
                fill_bytes[4] = a_reg[7:0];
                fill_bytes[5] = b_reg[15:8];
                fill_bytes[6] = b_reg[7:0];
                fill_len      = 4'd10;
            end
            hmf_pkg::CMD_TRIP_ONE,
            hmf_pkg::CMD_TRIP_TWO:
            begin
                fill_bytes[0] = (cmd_reg == hmf_pkg::CMD_TRIP_ONE) ?
                                hmf_pkg::KIND_TRIP_ONE : hmf_pkg::KIND_TRIP_TWO;
                fill_bytes[1] = cons_c1;
                fill_bytes[2] = cons_c2;
                fill_bytes[4] = b_reg[7:0];
                fill_bytes[5] = a_reg[15:8];
                fill_bytes[6] = a_reg[7:0];
                fill_len      = 4'd7;
            end
            default:
            begin
                // Temperature; unused codes are never latched.
                fill_bytes[0] = hmf_pkg::KIND_TEMP;
                fill_bytes[1] = temp_byte;
                fill_len      = 4'd2;
            end
        endcase
    end

    always_comb
    begin
        unique case (cmd.sel)
            hmf_pkg::SEL_HDR: byte_sel = hmf_pkg::FRAME_HEADER;
            hmf_pkg::SEL_LEN: byte_sel = {4'd0, len_reg} + hmf_pkg::LEN_EXTRA;
            hmf_pkg::SEL_PAY: byte_sel = pay_byte;
            hmf_pkg::SEL_SUM: byte_sel = sum_reg;
            default:          byte_sel = hmf_pkg::FRAME_HEADER;
        endcase
    end

    always_comb
    begin
        len_next       = len_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.fill)
        begin
            len_next = fill_len;
            idx_next = 4'd0;
            sum_next = {4'd0, fill_len} + hmf_pkg::LEN_EXTRA;
        end
        if (cmd.push)
        begin
            out_valid_next = 1'b1;
            if (cmd.sel == hmf_pkg::SEL_PAY)
            begin
                sum_next = sum_reg + pay_byte;
                idx_next = idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= 4'd0;
            idx_reg       <= 4'd0;
            sum_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg <= command;
            sv_reg  <= small_value;
            a_reg   <= word_a;
            b_reg   <= word_b;
            h_reg   <= consumption_hundredths;
            t_reg   <= temperature;
        end
        if (cmd.fill)
        begin
            for (int i = 0; i < hmf_pkg::PAYLOAD_DEPTH; i++)
            begin
                store_reg[i] <= fill_bytes[i];
            end
        end
        if (cmd.push)
        begin
            out_byte_reg <= byte_sel;
            out_last_reg <= (cmd.sel == hmf_pkg::SEL_SUM);
        end
    end

endmodule

`default_nettype wire

@@ sv/hmf_ctrl.sv @@
// Controller state machine that sequences division, payload build and frame output.
`default_nettype none

module hmf_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_ready,
    output hmf_pkg::dp_cmd_t          cmd,
    input  wire hmf_pkg::dp_status_t  status
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_FILL = 3'd2;
    localparam logic [2:0] ST_HDR  = 3'd3;
    localparam logic [2:0] ST_LEN  = 3'd4;
    localparam logic [2:0] ST_PAY  = 3'd5;
    localparam logic [2:0] ST_SUM  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign req_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.fill   = 1'b0;
        cmd.push   = 1'b0;
        cmd.sel    = hmf_pkg::SEL_HDR;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && status.cmd_ok)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                cmd.fill   = 1'b1;
                state_next = ST_HDR;
            end
            ST_HDR:
            begin
                if (status.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                cmd.sel = hmf_pkg::SEL_LEN;
                if (status.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_PAY;
                end
            end
            ST_PAY:
            begin
                cmd.sel = hmf_pkg::SEL_PAY;
                if (status.out_free)
                begin
                    cmd.push = 1'b1;
                    if (status.pay_last)
                    begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                cmd.sel = hmf_pkg::SEL_SUM;
                if (status.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/head_unit_message_framer.sv @@
// Usage: the req channel takes one message request per word; command selects the
// kind (button, speed, car trip, trip one, trip two, temperature) and the other
// fields carry its values. Requests with an unused command are taken and dropped.
// The rsp channel returns the framed message one byte per word: header, length,
// payload and checksum, with last_byte high on the checksum.
// After a request is taken, the bit-serial divider runs to completion; the
// controller sees it done in ST_DIV, builds the payload in ST_FILL and then
// loads the header into the output word in ST_HDR. Each further byte follows
// in the next cycle while rsp is ready.
// Frames are 5 to 13 bytes long; req is ready again once the checksum word is
// loaded into the output register, so the next request overlaps the wait on
// that word.
// Reset clears the controller, the output valid and the frame counters; the
// payload store is written by every request before it is read.
// When rsp stalls, the output word holds and the frame sequencer waits.
`default_nettype none

module head_unit_message_framer (
    input  wire logic    clk,
    input  wire logic    rst_n,
    hmf_req_if.sink      req,
    hmf_byte_if.source   rsp
);

    hmf_pkg::dp_cmd_t    cmd;
    hmf_pkg::dp_status_t status;
    logic                req_ready;

    assign req.ready = req_ready;

    hmf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .cmd       (cmd),
        .status    (status)
    );

    hmf_datapath u_datapath (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .command                (req.command),
        .small_value            (req.small_value),
        .word_a                 (req.word_a),
        .word_b                 (req.word_b),
        .consumption_hundredths (req.consumption_hundredths),
        .temperature            (req.temperature),
        .cmd                    (cmd),
        .status                 (status),
        .out_valid              (rsp.valid),
        .out_ready              (rsp.ready),
        .out_byte               (rsp.out_byte),
        .last_byte              (rsp.last_byte)
    );

endmodule

`default_nettype wire

@@ sv/hmf_checker.sv @@
// Port-level checks on the framer's output sequence, bound to the top level.
`default_nettype none

module hmf_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       rsp_valid,
    input  wire logic       rsp_ready,
    input  wire logic [7:0] out_byte,
    input  wire logic       last_byte
);

    logic       rsp_fire;
    logic       first_reg;
    logic [3:0] cnt_reg;

    assign rsp_fire = rsp_valid && rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b1;
            cnt_reg   <= 4'd0;
        end
        else if (rsp_fire)
        begin
            first_reg <= last_byte;
            cnt_reg   <= last_byte ? 4'd0 : (cnt_reg + 4'd1);
        end
    end

    // A stalled word keeps its value.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_byte) && $stable(last_byte))
        else $error("output word changed while stalled");

    // Every frame opens with the header word.
    a_header_first: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_fire && first_reg |-> out_byte == hmf_pkg::FRAME_HEADER && !last_byte)
        else $error("frame does not start with the header");

    // A frame never runs past thirteen words.
    a_frame_len: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_fire && !last_byte |-> cnt_reg < 4'd12)
        else $error("frame longer than thirteen words");

    // Reset clears the output channel.
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !rsp_valid)
        else $error("output valid during reset");

endmodule

bind head_unit_message_framer hmf_checker u_hmf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .out_byte  (rsp.out_byte),
    .last_byte (rsp.last_byte)
);

`default_nettype wire
